// ----- sv/fpt_pkg.sv -----
// Package for the Fermat primality test block: widths, verdict codes and
// sequencer states. No dependencies.
`timescale 1ns / 1ps

package fpt_pkg;

    localparam int FPT_NUM_WIDTH = 31;
    localparam int FPT_VERDICT_W = 2;

    typedef enum logic [FPT_VERDICT_W-1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_INVALID   = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_LOOP,
        ST_SQR,
        ST_SQ_EVAL,
        ST_MUL,
        ST_FINISH
    } t_state;

endpackage

// ----- sv/fpt_if.sv -----
// Valid/ready channel interfaces for the Fermat primality test block.
// Depends on fpt_pkg for default widths.
`timescale 1ns / 1ps

interface fpt_in_if #(parameter int NUM_WIDTH = fpt_pkg::FPT_NUM_WIDTH);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] candidate;
    logic [NUM_WIDTH-1:0] base;

    modport source (output valid, candidate, base, input ready);
    modport sink   (input valid, candidate, base, output ready);
endinterface

interface fpt_out_if;
    logic                               valid;
    logic                               ready;
    logic [fpt_pkg::FPT_VERDICT_W-1:0]  verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

// ----- sv/fermat_primality_test.sv -----
// Fermat primality test: one trial of A^(P-1) mod P per request, computed by
// one shared shift-and-add modular multiply step under a small sequencer.
// Depends on fpt_pkg and the channel interfaces in fpt_if.sv.
//
//   Channel  Dir  Handshake      Payload
//   i_in     in   valid/ready    candidate [NUM_WIDTH], base [NUM_WIDTH]
//   o_out    out  valid/ready    verdict [2]: 0 composite, 1 prime, 2 invalid
//
// One request is taken at a time; i_in.ready is high only while the block is
// idle. An accepted request is first range-checked; an invalid one goes
// straight to the output stage. For a valid one the exponent P-1 is shifted
// past its leading zeros to its leading one, and each bit below that one is
// processed with a modular square, plus a multiply by the base when the bit
// is one. A square that is a nontrivial root of 1 ends the trial as composite.
// The modular multiplier retires one multiplier bit per cycle. Reset is
// synchronous and active low and returns the sequencer to idle with the
// output empty. A stalled output holds its verdict; the next request is
// accepted while it waits, and that request waits in its last cycle until
// the output register is free.
`timescale 1ns / 1ps

module fermat_primality_test #(
    parameter int NUM_WIDTH = fpt_pkg::FPT_NUM_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpt_in_if.sink     i_in,
    fpt_out_if.source  o_out
);
    import fpt_pkg::*;

    // Counters index bit positions 0..NUM_WIDTH-1.
    localparam int CW = $clog2(NUM_WIDTH);
    // Width of 2*r + a, with r and a below P.
    localparam int TW = NUM_WIDTH + 2;

    t_state               r_state, n_state;
    logic [NUM_WIDTH-1:0] r_p, n_p;         // modulus P
    logic [NUM_WIDTH-1:0] r_a, n_a;         // base A
    logic [NUM_WIDTH-1:0] r_pm1, n_pm1;     // P-1
    logic [NUM_WIDTH-1:0] r_exp, n_exp;     // exponent, consumed from the MSB
    logic [CW-1:0]        r_rem, n_rem;     // exponent bits still to process
    logic [NUM_WIDTH-1:0] r_x, n_x;         // running power
    logic [NUM_WIDTH-1:0] r_ma, n_ma;       // multiplicand
    logic [NUM_WIDTH-1:0] r_mb, n_mb;       // multiplier, shifted out at the MSB
    logic [NUM_WIDTH-1:0] r_acc, n_acc;     // partial product, always below P
    logic [CW-1:0]        r_mcnt, n_mcnt;   // multiplier bits left minus one
    t_verdict             r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_verdict             r_out_verdict, n_out_verdict;

    logic                 w_invalid;
    logic                 w_slot_free;
    logic [TW-1:0]        w_sum;
    logic [TW:0]          w_sub1;
    logic [TW:0]          w_sub2;
    logic [NUM_WIDTH-1:0] w_step;

    // The request is invalid when P < 4, A < 2 or A > P-2 (written A+2 > P so
    // that nothing wraps).
    assign w_invalid = (r_p < NUM_WIDTH'(4)) || (r_a < NUM_WIDTH'(2)) ||
                       (({1'b0, r_a} + (NUM_WIDTH+1)'(2)) > {1'b0, r_p});

    // One step of the shared modular multiplier: acc = (2*acc + bit*ma) mod P.
    // The sum is below 3P, so P and 2P are subtracted in parallel and the
    // smallest result that does not borrow is kept.
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0} + (r_mb[NUM_WIDTH-1] ? {2'b00, r_ma} : TW'(0));
        w_sub1 = {1'b0, w_sum} - {3'b000, r_p};
        w_sub2 = {1'b0, w_sum} - {2'b00, r_p, 1'b0};
        if (!w_sub2[TW]) begin
            w_step = w_sub2[NUM_WIDTH-1:0];
        end else if (!w_sub1[TW]) begin
            w_step = w_sub1[NUM_WIDTH-1:0];
        end else begin
            w_step = w_sum[NUM_WIDTH-1:0];
        end
    end

    assign w_slot_free = !r_out_valid || o_out.ready;

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_out_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_p           <= n_p;
        r_a           <= n_a;
        r_pm1         <= n_pm1;
        r_exp         <= n_exp;
        r_rem         <= n_rem;
        r_x           <= n_x;
        r_ma          <= n_ma;
        r_mb          <= n_mb;
        r_acc         <= n_acc;
        r_mcnt        <= n_mcnt;
        r_res         <= n_res;
        r_out_verdict <= n_out_verdict;
    end

    always_comb begin
        n_state       = r_state;
        n_p           = r_p;
        n_a           = r_a;
        n_pm1         = r_pm1;
        n_exp         = r_exp;
        n_rem         = r_rem;
        n_x           = r_x;
        n_ma          = r_ma;
        n_mb          = r_mb;
        n_acc         = r_acc;
        n_mcnt        = r_mcnt;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_verdict = r_out_verdict;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_p     = i_in.candidate;
                    n_a     = i_in.base;
                    n_state = ST_CHECK;
                end
            end

            ST_CHECK: begin
                // Range check, then prepare the exponent P-1 for the
                // leading-one search.
                n_pm1 = r_p - NUM_WIDTH'(1);
                n_exp = r_p - NUM_WIDTH'(1);
                n_rem = CW'(NUM_WIDTH - 1);
                if (w_invalid) begin
                    n_res   = VERDICT_INVALID;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_NORM;
                end
            end

            ST_NORM: begin
                // Shift the exponent up until its leading one drops out. The
                // count left behind is the number of lower bits to process;
                // P-1 >= 3 guarantees at least one.
                n_exp = {r_exp[NUM_WIDTH-2:0], 1'b0};
                if (r_exp[NUM_WIDTH-1]) begin
                    n_x     = r_a;
                    n_state = ST_LOOP;
                end else begin
                    n_rem = r_rem - CW'(1);
                end
            end

            ST_LOOP: begin
                if (r_rem == CW'(0)) begin
                    n_res   = (r_x == NUM_WIDTH'(1)) ? VERDICT_PRIME : VERDICT_COMPOSITE;
                    n_state = ST_FINISH;
                end else begin
                    // Launch the square of the running power.
                    n_ma    = r_x;
                    n_mb    = r_x;
                    n_acc   = '0;
                    n_mcnt  = CW'(NUM_WIDTH - 1);
                    n_state = ST_SQR;
                end
            end

            ST_SQR: begin
                n_acc  = w_step;
                n_mb   = {r_mb[NUM_WIDTH-2:0], 1'b0};
                n_mcnt = r_mcnt - CW'(1);
                if (r_mcnt == CW'(0)) begin
                    n_state = ST_SQ_EVAL;
                end
            end

            ST_SQ_EVAL: begin
                // A square equal to 1 from anything but 1 or P-1 is a
                // nontrivial square root of 1, so P is composite.
                if ((r_acc == NUM_WIDTH'(1)) && (r_x != NUM_WIDTH'(1)) &&
                    (r_x != r_pm1)) begin
                    n_res   = VERDICT_COMPOSITE;
                    n_state = ST_FINISH;
                end else if (r_exp[NUM_WIDTH-1]) begin
                    // Exponent bit is one: multiply the square by the base.
                    n_ma    = r_acc;
                    n_mb    = r_a;
                    n_acc   = '0;
                    n_mcnt  = CW'(NUM_WIDTH - 1);
                    n_state = ST_MUL;
                end else begin
                    n_x     = r_acc;
                    n_exp   = {r_exp[NUM_WIDTH-2:0], 1'b0};
                    n_rem   = r_rem - CW'(1);
                    n_state = ST_LOOP;
                end
            end

            ST_MUL: begin
                n_acc  = w_step;
                n_mb   = {r_mb[NUM_WIDTH-2:0], 1'b0};
                n_mcnt = r_mcnt - CW'(1);
                if (r_mcnt == CW'(0)) begin
                    // This step completes the product, so w_step is committed to the
                    // running power as it is loaded into r_acc.
                    n_x     = w_step;
                    n_exp   = {r_exp[NUM_WIDTH-2:0], 1'b0};
                    n_rem   = r_rem - CW'(1);
                    n_state = ST_LOOP;
                end
            end

            ST_FINISH: begin
                // Wait for the output register to be free, then hand over.
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_res;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The modular multiplier keeps its partial product reduced below P.
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ_EVAL) |-> (r_acc < r_p))
        else $error("partial product not reduced below the modulus");

    // The running power stays a residue of P throughout the exponent loop.
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOP) |-> (r_x < r_p))
        else $error("running power not reduced below the modulus");

    // Only defined verdict codes reach the output.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_verdict == VERDICT_COMPOSITE ||
                         r_out_verdict == VERDICT_PRIME ||
                         r_out_verdict == VERDICT_INVALID))
        else $error("undefined verdict code on the output");

    // A result is loaded only when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_verdict)))
        else $error("pending verdict overwritten or dropped");

endmodule
